### hdl/rbrf_pkg.sv
package rbrf_pkg;

    localparam int RING_SLOTS = 128;
    localparam int MAX_GROUPS = 16;

    localparam int GRP_W    = 4;
    localparam int BLK_W    = 32;
    localparam int DROP_W   = 8;
    localparam int GCNT_W   = 5;
    localparam int SLOT_W   = $clog2(RING_SLOTS);
    localparam int CNT_W    = $clog2(RING_SLOTS + 1);
    localparam int ADDR_W   = $clog2(MAX_GROUPS * RING_SLOTS);
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;
    localparam int CIDX_W   = 1;

    localparam logic [BLK_W-1:0] CORRUPT_MARK = 32'hFFFF_FFFF;
    localparam logic [DROP_W-1:0] DROP_MAX    = '1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_GROUP_COUNT = 1'b0,
        REG_BLOCK_LIMIT = 1'b1
    } reg_index_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(RING_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_addr(
        input logic [GRP_W-1:0]  g,
        input logic [SLOT_W-1:0] s
    );
        return ADDR_W'(ADDR_W'(g) * ADDR_W'(RING_SLOTS)) + ADDR_W'(s);
    endfunction

endpackage

### hdl/reserved_block_ring_freelist.sv
// Per-group circular free lists of reserved block numbers, 16 groups of 128 slots, held in
// one 2048 x 32 synchronous memory with head, tail and count kept in flip-flops per group.
// A put, a bad group index, or a get on an empty list is answered in the accept cycle.
// A get on a non-empty list moves to a read state that drops corrupt head entries and
// answers with the first valid entry, or with empty status if it drops every remaining
// entry. The scan reads one memory entry per cycle through the single read port, and a
// full output register holds the last step until it is taken.
// One transaction is in flight at a time; the input is taken only while the
// output register is free or being emptied. The store needs no clearing pass after reset.
module reserved_block_ring_freelist
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rbrf_pkg::CIDX_W-1:0] cfg_index,
    input  logic [rbrf_pkg::BLK_W-1:0]  cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // group_index [3:0], block_number [35:4], zero pad [39:36]
    input  logic [rbrf_pkg::IN_W-1:0]   s_axis_tdata,
    // kind
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // result_block [31:0], dropped_entries [39:32]
    output logic [rbrf_pkg::OUT_W-1:0]  m_axis_tdata,
    // status
    output logic [1:0]                  m_axis_tuser
);
    import rbrf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [GCNT_W-1:0] group_count_reg;
    logic [BLK_W-1:0]  block_limit_reg;

    logic [SLOT_W-1:0] head_reg  [MAX_GROUPS];
    logic [SLOT_W-1:0] tail_reg  [MAX_GROUPS];
    logic [CNT_W-1:0]  count_reg [MAX_GROUPS];

    logic [BLK_W-1:0]  ring_mem [MAX_GROUPS * RING_SLOTS];
    logic [BLK_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [GRP_W-1:0]  grp_reg;
    logic [DROP_W-1:0] drop_reg, drop_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [BLK_W-1:0]  out_block_reg;
    logic [DROP_W-1:0] out_drop_reg;

    logic [GRP_W-1:0]  in_grp;
    logic [BLK_W-1:0]  in_blk;
    kind_t             in_kind;
    logic              accept;
    logic              out_free;
    logic              bad_grp;

    logic [GRP_W-1:0]  g_sel;
    logic [SLOT_W-1:0] cur_head, cur_tail;
    logic [CNT_W-1:0]  cur_count;

    logic              upd_en;
    logic [SLOT_W-1:0] head_upd, tail_upd;
    logic [CNT_W-1:0]  count_upd;

    logic              out_load;
    status_t           res_status;
    logic [BLK_W-1:0]  res_block;
    logic [DROP_W-1:0] res_drop;
    logic              corrupt;
    logic [SLOT_W-1:0] put_slot;
    logic [SLOT_W-1:0] rd_slot;

    assign in_grp   = s_axis_tdata[GRP_W-1:0];
    assign in_blk   = s_axis_tdata[GRP_W+BLK_W-1:GRP_W];
    assign in_kind  = kind_t'(s_axis_tuser);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign bad_grp  = (GCNT_W'(in_grp) >= group_count_reg)
                      || (32'(in_grp) >= 32'(MAX_GROUPS));

    assign g_sel     = (state_reg == S_IDLE) ? in_grp : grp_reg;
    assign cur_head  = head_reg[g_sel];
    assign cur_tail  = tail_reg[g_sel];
    assign cur_count = count_reg[g_sel];

    assign corrupt  = (rd_data_reg == CORRUPT_MARK) || (rd_data_reg >= block_limit_reg);
    assign put_slot = (cur_count == '0) ? '0 : next_slot(cur_tail);

    always_comb
    begin
        state_next = state_reg;
        drop_next  = drop_reg;
        upd_en     = 1'b0;
        head_upd   = cur_head;
        tail_upd   = cur_tail;
        count_upd  = cur_count;
        wr_en      = 1'b0;
        wr_addr    = ring_addr(in_grp, put_slot);
        rd_slot    = cur_head;
        out_load   = 1'b0;
        res_status = ST_OK;
        res_block  = '0;
        res_drop   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (bad_grp)
                    begin
                        out_load   = 1'b1;
                        res_status = ST_BAD;
                    end
                    else if (in_kind == KIND_PUT)
                    begin
                        out_load = 1'b1;
                        if (cur_count >= CNT_W'(RING_SLOTS))
                        begin
                            res_status = ST_FULL;
                            res_block  = in_blk;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            upd_en    = 1'b1;
                            tail_upd  = put_slot;
                            count_upd = cur_count + CNT_W'(1);
                            if (cur_count == '0)
                            begin
                                head_upd = '0;
                            end
                        end
                    end
                    else if (cur_count == '0)
                    begin
                        out_load   = 1'b1;
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        drop_next  = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (corrupt)
                begin
                    if (cur_count != CNT_W'(1) || out_free)
                    begin
                        upd_en    = 1'b1;
                        head_upd  = next_slot(cur_head);
                        count_upd = cur_count - CNT_W'(1);
                        rd_slot   = head_upd;
                        drop_next = (drop_reg == DROP_MAX) ? drop_reg : drop_reg + DROP_W'(1);
                        if (cur_count == CNT_W'(1))
                        begin
                            out_load   = 1'b1;
                            res_status = ST_EMPTY;
                            res_drop   = drop_next;
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (out_free)
                begin
                    upd_en     = 1'b1;
                    head_upd   = next_slot(cur_head);
                    count_upd  = cur_count - CNT_W'(1);
                    out_load   = 1'b1;
                    res_block  = rd_data_reg;
                    res_drop   = drop_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = ring_addr(g_sel, rd_slot);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= in_blk;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            group_count_reg <= GCNT_W'(1);
            block_limit_reg <= '1;
            out_valid_reg   <= 1'b0;
            grp_reg         <= '0;
            drop_reg        <= '0;
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            drop_reg  <= drop_next;
            if (accept)
            begin
                grp_reg <= in_grp;
            end
            if (cfg_wr_en)
            begin
                case (reg_index_t'(cfg_index))
                    REG_GROUP_COUNT: group_count_reg <= cfg_data[GCNT_W-1:0];
                    REG_BLOCK_LIMIT: block_limit_reg <= cfg_data;
                    default:         block_limit_reg <= block_limit_reg;
                endcase
            end
            if (upd_en)
            begin
                head_reg[g_sel]  <= head_upd;
                tail_reg[g_sel]  <= tail_upd;
                count_reg[g_sel] <= count_upd;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_block_reg  <= res_block;
            out_drop_reg   <= res_drop;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_drop_reg, out_block_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule
